// ===== src/lpcg_pkg.sv =====
package lpcg_pkg;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    localparam logic [2:0] PAL_RAINBOW    = 3'd0;
    localparam logic [2:0] PAL_WHEEL      = 3'd1;
    localparam logic [2:0] PAL_FLAME      = 3'd2;
    localparam logic [2:0] PAL_COLD       = 3'd3;
    localparam logic [2:0] PAL_WARM       = 3'd4;
    localparam logic [2:0] PAL_ICE_TINT   = 3'd5;
    localparam logic [2:0] PAL_AMBER_TINT = 3'd6;
    localparam logic [2:0] PAL_NONE       = 3'd7;

    localparam logic [7:0] WHEEL_SEG1 = 8'd85;
    localparam logic [7:0] WHEEL_SEG2 = 8'd170;
    localparam logic [7:0] FULL       = 8'd255;
    localparam logic [6:0] FLAME_HALF = 7'd42;
    localparam logic [6:0] FLAME_TOP  = 7'd84;
    localparam logic [6:0] RAMP_FOLD  = 7'd127;

    localparam t_rgb ICE_TINT   = '{red: 8'hF0, green: 8'hF8, blue: 8'hFF};
    localparam t_rgb AMBER_TINT = '{red: 8'hFF, green: 8'hCF, blue: 8'h48};
    localparam t_rgb BLACK      = '{red: 8'h00, green: 8'h00, blue: 8'h00};

    localparam t_rgb RAINBOW_TAB [7] = '{
        '{red: 8'hFF, green: 8'h00, blue: 8'h00},
        '{red: 8'hFF, green: 8'h7F, blue: 8'h00},
        '{red: 8'hFF, green: 8'hFF, blue: 8'h00},
        '{red: 8'h00, green: 8'hFF, blue: 8'h00},
        '{red: 8'h42, green: 8'hAA, blue: 8'hFF},
        '{red: 8'h00, green: 8'h00, blue: 8'hFF},
        '{red: 8'h8B, green: 8'h00, blue: 8'hFF}
    };

    // three-segment red -> green -> blue wheel
    function automatic t_rgb wheel(input logic [7:0] p);
        t_rgb       c;
        logic [7:0] q;
        logic [7:0] q3;
        if (p < WHEEL_SEG1) begin
            q3      = (p << 1) + p;
            c.red   = FULL - q3;
            c.green = q3;
            c.blue  = 8'd0;
        end else if (p < WHEEL_SEG2) begin
            q       = p - WHEEL_SEG1;
            q3      = (q << 1) + q;
            c.red   = 8'd0;
            c.green = FULL - q3;
            c.blue  = q3;
        end else begin
            q       = p - WHEEL_SEG2;
            q3      = (q << 1) + q;
            c.red   = q3;
            c.green = 8'd0;
            c.blue  = FULL - q3;
        end
        return c;
    endfunction

endpackage

// ===== src/led_palette_color_generator.sv =====
// LED palette color generator.
// Input channel: i_valid / o_stall with i_palette (3 bits) and i_color_index
// (8 bits). An item is taken at a clock edge with i_valid high and o_stall low.
// Output channel: o_valid / i_stall with o_red, o_green, o_blue. A color is
// taken at a clock edge with o_valid high and i_stall low.
// Each item yields exactly one color; palette code 7 gives black.
// An item taken at an edge sits in the input register; its color moves into
// the result register, with o_valid high, once that register is empty or
// i_stall is low. Throughput: one item per cycle while i_stall is low; the
// color math is a single combinational pass between the two registers.
// While the receiver stalls, the result register holds its color and the
// input register can still take one more item, so o_stall rises only while
// both registers are full and i_stall is high. o_stall depends
// combinationally on i_stall.
// Reset (i_rst_n low, synchronous) empties both registers; o_valid drops.
module led_palette_color_generator (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [2:0] i_palette,
    input  logic [7:0] i_color_index,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_red,
    output logic [7:0] o_green,
    output logic [7:0] o_blue
);

    logic                r_s1_valid;
    logic [2:0]          r_s1_palette;
    logic [7:0]          r_s1_index;
    logic                r_out_valid;
    lpcg_pkg::t_rgb      r_out_color;
    lpcg_pkg::t_rgb      n_color;

    logic                s1_move;
    logic                in_acc;

    logic [4:0]          m7_a;
    logic [3:0]          m7_b;
    logic [2:0]          idx_mod7;
    logic [14:0]         flame_prod;
    logic [15:0]         flame_sum;
    logic [6:0]          flame_s;
    logic [6:0]          flame_pos;
    logic [6:0]          ramp_k;
    logic [7:0]          ramp_2k;

    assign s1_move = r_s1_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_s1_valid && !s1_move;
    assign in_acc  = i_valid && !o_stall;

    always_comb begin
        // mod 7 by summing octal digits, since 8 == 1 (mod 7)
        m7_a = {2'b00, r_s1_index[2:0]} + {2'b00, r_s1_index[5:3]}
             + {3'b000, r_s1_index[7:6]};
        m7_b = {1'b0, m7_a[2:0]} + {2'b00, m7_a[4:3]};
        idx_mod7 = (m7_b >= 4'd7) ? 3'(m7_b - 4'd7) : m7_b[2:0];

        // s = idx * 84 / 255, division via (x + (x >> 8) + 1) >> 8
        flame_prod = ({7'd0, r_s1_index} << 6) + ({7'd0, r_s1_index} << 4)
                   + ({7'd0, r_s1_index} << 2);
        flame_sum  = {1'b0, flame_prod} + {9'd0, flame_prod[14:8]} + 16'd1;
        flame_s    = flame_sum[14:8];
        if (flame_s < lpcg_pkg::FLAME_HALF) begin
            flame_pos = flame_s;
        end else if (flame_s == lpcg_pkg::FLAME_TOP) begin
            flame_pos = 7'd0;
        end else begin
            flame_pos = lpcg_pkg::FLAME_TOP - flame_s;
        end

        ramp_k  = r_s1_index[7] ? (lpcg_pkg::RAMP_FOLD - r_s1_index[6:0])
                                : r_s1_index[6:0];
        ramp_2k = {ramp_k, 1'b0};

        case (r_s1_palette)
            lpcg_pkg::PAL_RAINBOW: begin
                n_color = lpcg_pkg::RAINBOW_TAB[idx_mod7];
            end
            lpcg_pkg::PAL_WHEEL: begin
                n_color = lpcg_pkg::wheel(r_s1_index);
            end
            lpcg_pkg::PAL_FLAME: begin
                n_color = lpcg_pkg::wheel({1'b0, flame_pos});
            end
            lpcg_pkg::PAL_COLD: begin
                n_color.red   = 8'd0;
                n_color.green = lpcg_pkg::FULL - ramp_2k;
                n_color.blue  = ramp_2k;
            end
            lpcg_pkg::PAL_WARM: begin
                n_color.red   = lpcg_pkg::FULL - ramp_2k;
                n_color.green = 8'd0;
                n_color.blue  = ramp_2k;
            end
            lpcg_pkg::PAL_ICE_TINT: begin
                n_color = lpcg_pkg::ICE_TINT;
            end
            lpcg_pkg::PAL_AMBER_TINT: begin
                n_color = lpcg_pkg::AMBER_TINT;
            end
            default: begin
                n_color = lpcg_pkg::BLACK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_move) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_palette <= i_palette;
            r_s1_index   <= i_color_index;
        end
        if (s1_move) begin
            r_out_color <= n_color;
        end
    end

    assign o_valid = r_out_valid;
    assign o_red   = r_out_color.red;
    assign o_green = r_out_color.green;
    assign o_blue  = r_out_color.blue;

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !r_s1_valid)
        else $error("pipeline not empty after reset");

    a_stall_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && r_out_valid && i_stall |-> o_stall)
        else $error("input taken while both registers full");

    a_no_stall_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_s1_valid |-> !o_stall)
        else $error("stall raised with empty input register");

    a_accept_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_s1_valid)
        else $error("accepted item lost in input register");

    a_none_is_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_move && r_s1_palette == lpcg_pkg::PAL_NONE
        |=> o_valid && o_red == 8'd0 && o_green == 8'd0 && o_blue == 8'd0)
        else $error("undefined palette did not give black");

endmodule
